>>> rtl/core/delta_patch_command_decoder_assert.svh
// Assertion macros shared by the delta patch command decoder RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DELTA_PATCH_COMMAND_DECODER_ASSERT_SVH
`define DELTA_PATCH_COMMAND_DECODER_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define DPCD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define DPCD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/dpcd_pkg.sv
// Types and constants of the delta patch command decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package dpcd_pkg;

   localparam int unsigned NUM_W = 31;

   localparam logic [1:0] KIND_LITERAL = 2'd0;
   localparam logic [1:0] KIND_COPY    = 2'd1;
   localparam logic [1:0] KIND_OK      = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   localparam logic [7:0] LONG_FLAG = 8'd128;
   localparam logic [7:0] LOW_MASK  = 8'd127;

   typedef enum logic [2:0] {
      PH_HEAD,
      PH_POS,
      PH_POS_LONG,
      PH_LEN,
      PH_LEN_LONG,
      PH_LIT
   } phase_type;

   typedef struct packed {
      logic [7:0] diff_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [7:0]       literal_value;
      logic [NUM_W-1:0] copy_position;
      logic [NUM_W-1:0] copy_length;
      logic             run_end;
   } rsp_type;

   // Everything one input item produces: an optional data result
   // (literal, copy or invalid copy) and an optional end-of-stream result.
   typedef struct packed {
      logic             first_valid;
      logic [1:0]       first_kind;
      logic [7:0]       literal_value;
      logic [NUM_W-1:0] copy_position;
      logic [NUM_W-1:0] copy_length;
      logic             last_valid;
      logic [1:0]       last_kind;
   } event_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

>>> rtl/core/dpcd_front.sv
// Front end of the delta patch command decoder: parser state and copy check.
// Depends on dpcd_pkg; emits one event per accepted byte that has results.
`default_nettype none

module dpcd_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  dpcd_pkg::req_type            req_data,
   input  logic [dpcd_pkg::NUM_W-1:0]   base_length,
   output dpcd_pkg::event_type          evt,
   output logic                         evt_push
);
   import dpcd_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [1:0]       seen_ff, seen_in;
   logic [NUM_W-1:0] acc_ff, acc_in;
   logic [NUM_W-1:0] held_ff, held_in;
   logic [7:0]       lit_rem_ff, lit_rem_in;
   logic             discard_ff, discard_in;

   logic [7:0]       b;
   logic             stream_end;
   logic             is_pos, is_long, long_n, in_num, num_done, copy_ok, copy_fail;
   phase_type        phase_num, phase_after;
   logic [NUM_W-1:0] acc_num;
   logic [1:0]       seen_num;
   logic [7:0]       lit_rem_dec;

   assign b          = req_data.diff_byte;
   assign stream_end = req_data.stream_end;

   always_comb begin : decode
      is_pos    = (phase_ff == PH_POS) || (phase_ff == PH_POS_LONG);
      is_long   = (phase_ff == PH_POS_LONG) || (phase_ff == PH_LEN_LONG);
      in_num    = (phase_ff != PH_HEAD) && (phase_ff != PH_LIT);
      long_n    = is_long;
      phase_num = phase_ff;
      if (seen_ff == 2'd0) begin
         acc_num = {{(NUM_W-7){1'b0}}, b[6:0] & LOW_MASK[6:0]};
         if ((b & LONG_FLAG) != 8'd0) begin
            long_n    = 1'b1;
            phase_num = is_pos ? PH_POS_LONG : PH_LEN_LONG;
         end
      end else begin
         acc_num = {acc_ff[NUM_W-9:0], b};
      end
      seen_num    = seen_ff + 2'd1;
      num_done    = long_n ? (seen_num == 2'd0) : (seen_num != 2'd1);
      copy_ok     = (held_ff < base_length) && ((base_length - held_ff) >= acc_num);
      copy_fail   = in_num && num_done && !is_pos && !copy_ok;
      lit_rem_dec = lit_rem_ff - 8'd1;
      unique case (phase_ff)
         PH_HEAD: phase_after = (b == 8'd0) ? PH_POS : PH_LIT;
         PH_LIT:  phase_after = (lit_rem_dec == 8'd0) ? PH_HEAD : PH_LIT;
         default: phase_after = num_done ? (is_pos ? PH_LEN : PH_HEAD) : phase_num;
      endcase
   end

   always_comb begin : next_state
      phase_in   = phase_ff;
      seen_in    = seen_ff;
      acc_in     = acc_ff;
      held_in    = held_ff;
      lit_rem_in = lit_rem_ff;
      discard_in = discard_ff;
      if (accept) begin
         if (discard_ff) begin
            if (stream_end) begin
               phase_in   = PH_HEAD;
               seen_in    = 2'd0;
               acc_in     = '0;
               held_in    = '0;
               lit_rem_in = 8'd0;
               discard_in = 1'b0;
            end
         end else begin
            phase_in = phase_after;
            unique case (phase_ff)
               PH_HEAD: begin
                  if (b != 8'd0) begin
                     lit_rem_in = b;
                  end
                  seen_in = 2'd0;
                  acc_in  = '0;
               end
               PH_LIT: begin
                  lit_rem_in = lit_rem_dec;
               end
               default: begin
                  if (num_done) begin
                     seen_in = 2'd0;
                     acc_in  = '0;
                     held_in = is_pos ? acc_num : '0;
                  end else begin
                     seen_in = seen_num;
                     acc_in  = acc_num;
                  end
               end
            endcase
            if (stream_end) begin
               phase_in   = PH_HEAD;
               seen_in    = 2'd0;
               acc_in     = '0;
               held_in    = '0;
               lit_rem_in = 8'd0;
               discard_in = 1'b0;
            end else if (copy_fail) begin
               discard_in = 1'b1;
            end
         end
      end
   end

   always_comb begin : outputs
      evt = '0;
      if (accept && !discard_ff) begin
         if (phase_ff == PH_LIT) begin
            evt.first_valid   = 1'b1;
            evt.first_kind    = KIND_LITERAL;
            evt.literal_value = b;
         end else if (in_num && num_done && !is_pos) begin
            evt.first_valid = 1'b1;
            if (copy_ok) begin
               evt.first_kind    = KIND_COPY;
               evt.copy_position = held_ff;
               evt.copy_length   = acc_num;
            end else begin
               evt.first_kind = KIND_INVALID;
            end
         end
         if (stream_end && !copy_fail) begin
            evt.last_valid = 1'b1;
            evt.last_kind  = (phase_after == PH_HEAD) ? KIND_OK : KIND_INVALID;
         end
      end
      evt_push = evt.first_valid || evt.last_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEAD;
         seen_ff    <= 2'd0;
         acc_ff     <= '0;
         held_ff    <= '0;
         lit_rem_ff <= 8'd0;
         discard_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         seen_ff    <= seen_in;
         acc_ff     <= acc_in;
         held_ff    <= held_in;
         lit_rem_ff <= lit_rem_in;
         discard_ff <= discard_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/dpcd_queue.sv
// Short event queue between the front end and the result sequencer.
// Depends on dpcd_pkg for the event and status types.
`default_nettype none

module dpcd_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  dpcd_pkg::event_type        push_data,
   input  logic                       pop,
   output dpcd_pkg::event_type        head,
   output dpcd_pkg::queue_status_type status
);
   import dpcd_pkg::*;

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   event_type        mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head             = mem_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == CW'(DEPTH));

endmodule

`default_nettype wire

>>> rtl/core/dpcd_back.sv
// Back end of the delta patch command decoder: turns queued events into results.
// Depends on dpcd_pkg; drives the registered result channel.
`default_nettype none

module dpcd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  dpcd_pkg::event_type        head,
   input  dpcd_pkg::queue_status_type status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output dpcd_pkg::rsp_type          rsp_data
);
   import dpcd_pkg::*;

   logic    second_ff, second_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    cur_first, is_final, load;

   always_comb begin
      cur_first = head.first_valid && !second_ff;
      is_final  = !cur_first || !head.last_valid;
      load      = status.not_empty && (!rsp_valid_ff || rsp_ready);
      pop       = load && is_final;

      if (cur_first) begin
         rsp_data_in.kind          = head.first_kind;
         rsp_data_in.literal_value = head.literal_value;
         rsp_data_in.copy_position = head.copy_position;
         rsp_data_in.copy_length   = head.copy_length;
         rsp_data_in.run_end       = !head.last_valid;
      end else begin
         rsp_data_in               = '0;
         rsp_data_in.kind          = head.last_kind;
         rsp_data_in.run_end       = 1'b1;
      end

      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         second_in    = !is_final;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/delta_patch_command_decoder.sv
// Order: an accepted byte's event is written into the event queue, then loaded into the output register.
// Throughput: one byte per cycle while the event queue has room; results leave one per
// cycle from the output register while the consumer is ready, so bytes with two results are drained at that rate.
// Reset is synchronous and active high: parser back to header, base_length to zero,
// queue and output register empty. No clearing pass is needed.
// Top level; depends on dpcd_pkg, dpcd_front, dpcd_queue, dpcd_back and the assert header.
`default_nettype none

module delta_patch_command_decoder #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  dpcd_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output dpcd_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [dpcd_pkg::NUM_W-1:0]  csr_wr_data
);
   import dpcd_pkg::*;

`include "delta_patch_command_decoder_assert.svh"

   // The base length register; the user must write it only while the block is idle; nothing here checks that.
   logic [NUM_W-1:0] base_length_ff;

   logic             accept;
   event_type        evt;
   logic             evt_push;
   event_type        q_head;
   queue_status_type q_status;
   logic             q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_length_ff <= '0;
      end else if (csr_wr_en) begin
         base_length_ff <= csr_wr_data;
      end
   end

   // The front end takes a byte whenever the queue is not full. A byte
   // that causes no result (a header, a number byte, a byte being discarded)
   // is consumed without a queue entry.
   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   dpcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .base_length (base_length_ff),
      .evt         (evt),
      .evt_push    (evt_push)
   );

   dpcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (evt_push),
      .push_data (evt),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   // The back end splits each event into one or two results and holds each
   // one in the output register until the consumer takes it.
   dpcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .status    (q_status),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // An event is never written into a full queue.
   `DPCD_ASSERT(a_no_push_full, clock, reset, evt_push |-> !q_status.full, "push into full queue")

   // The back end only removes events that are there.
   `DPCD_ASSERT(a_no_pop_empty, clock, reset, q_pop |-> q_status.not_empty, "pop from empty queue")

   // The second result of a byte follows its first without a gap.
   `DPCD_ASSERT(a_pair_follows, clock, reset, (rsp_valid && rsp_ready && !rsp_data.run_end) |=> rsp_valid, "second result missing")

endmodule

`default_nettype wire

>>> bench/tb.sv
// Self-checking testbench for the delta patch command decoder (top level only).
// Depends on dpcd_pkg and the decoder RTL; it feeds byte streams and checks
// every result against a behavioral predictor kept inside this module.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dpcd_pkg::*;

   localparam logic [31:0] MAX_LEN = 32'h7FFF_FFFF;

   // Clock, reset and the block's inputs all start at known values.
   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   req_type          req_data    = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en   = 1'b0;
   logic [NUM_W-1:0] csr_wr_data = '0;

   delta_patch_command_decoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Items waiting to be offered, results the decoder still owes us, and the
   // scratch buffer that one stream is assembled in before it is queued.
   req_type     pending_items[$];
   rsp_type     expected_rsps[$];
   logic [7:0]  stream_bytes[$];

   // Percentages of cycles in which each side holds back.
   int unsigned send_gap_pct   = 23;
   int unsigned recv_stall_pct = 53;

   int unsigned fail_count      = 0;
   int unsigned results_checked = 0;
   int unsigned stall_left      = 0;
   logic        long_stall_done = 1'b0;

   // Predictor state: a private copy of the parser and of base_length.
   phase_type        cur_phase;
   logic [1:0]       digits_seen;
   logic [NUM_W-1:0] number_acc;
   logic [NUM_W-1:0] held_pos;
   logic [7:0]       lit_left;
   logic             dropping;
   logic [NUM_W-1:0] base_size;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Every byte marked as the end of a stream returns the parser to its
   // starting state; the configured base length survives.
   function automatic void clear_parser();
      cur_phase   = PH_HEAD;
      digits_seen = '0;
      number_acc  = '0;
      held_pos    = '0;
      lit_left    = '0;
      dropping    = 1'b0;
   endfunction

   function automatic rsp_type make_rsp(logic [1:0] kind, logic [7:0] lit,
                                        logic [NUM_W-1:0] pos, logic [NUM_W-1:0] len);
      rsp_type r;
      r.kind          = kind;
      r.literal_value = lit;
      r.copy_position = pos;
      r.copy_length   = len;
      r.run_end       = 1'b0;
      return r;
   endfunction

   // Advances the predicted parser by one accepted byte and queues the
   // zero, one or two results that byte should produce.
   task automatic decode_byte(input req_type item);
      rsp_type          made[$];
      logic             failed;
      logic             is_pos;
      logic             is_long;
      logic [2:0]       got;
      logic [NUM_W-1:0] value;
      failed = 1'b0;

      // After a bad copy everything up to the end of the stream is dropped
      // without any result.
      if (dropping) begin
         if (item.stream_end) clear_parser();
         return;
      end

      case (cur_phase)
         PH_HEAD: begin
            // Zero opens a copy command; anything else is a literal count.
            if (item.diff_byte == 8'd0) begin
               cur_phase = PH_POS;
            end else begin
               lit_left  = item.diff_byte;
               cur_phase = PH_LIT;
            end
            digits_seen = '0;
            number_acc  = '0;
         end
         PH_LIT: begin
            made.push_back(make_rsp(KIND_LITERAL, item.diff_byte, '0, '0));
            lit_left = lit_left - 8'd1;
            if (lit_left == 8'd0) cur_phase = PH_HEAD;
         end
         default: begin
            is_pos  = (cur_phase == PH_POS || cur_phase == PH_POS_LONG);
            is_long = (cur_phase == PH_POS_LONG || cur_phase == PH_LEN_LONG);
            // The top bit of a number's first byte selects the 4-byte form
            // and is itself masked off.
            if (digits_seen == 2'd0) begin
               number_acc = {23'd0, item.diff_byte & LOW_MASK};
               if ((item.diff_byte & LONG_FLAG) != 8'd0) begin
                  is_long   = 1'b1;
                  cur_phase = is_pos ? PH_POS_LONG : PH_LEN_LONG;
               end
            end else begin
               number_acc = {number_acc[22:0], item.diff_byte};
            end
            digits_seen = digits_seen + 2'd1;
            got = (digits_seen == 2'd0) ? 3'd4 : {1'b0, digits_seen};
            if (got >= (is_long ? 3'd4 : 3'd2)) begin
               value       = number_acc;
               digits_seen = '0;
               number_acc  = '0;
               if (is_pos) begin
                  held_pos  = value;
                  cur_phase = PH_LEN;
               end else begin
                  cur_phase = PH_HEAD;
                  // A copy must start inside the base and fit in what is left.
                  if (held_pos < base_size && (base_size - held_pos) >= value) begin
                     made.push_back(make_rsp(KIND_COPY, 8'd0, held_pos, value));
                  end else begin
                     made.push_back(make_rsp(KIND_INVALID, 8'd0, '0, '0));
                     failed = 1'b1;
                  end
                  held_pos = '0;
               end
            end
         end
      endcase

      if (failed) begin
         if (item.stream_end) clear_parser();
         else dropping = 1'b1;
      end else if (item.stream_end) begin
         // A stream closes cleanly only at a command boundary.
         made.push_back(make_rsp((cur_phase == PH_HEAD) ? KIND_OK : KIND_INVALID,
                                 8'd0, '0, '0));
         clear_parser();
      end

      if (made.size() > 0) begin
         made[made.size() - 1].run_end = 1'b1;
         foreach (made[i]) expected_rsps.push_back(made[i]);
      end
   endtask

   // ------------------------------------------------------------------------
   // Stream construction
   // ------------------------------------------------------------------------

   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      return r[7:0];
   endfunction

   // Random value in [lo, hi], leaning toward both ends of the range.
   function automatic logic [31:0] pick_between(logic [31:0] lo, logic [31:0] hi);
      logic [31:0] span;
      span = hi - lo;
      case ($urandom_range(0, 3))
         0: return lo;
         1: return hi;
         2: return lo + $urandom_range(0, (span > 32'd300) ? 300 : span);
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   // Appends a number in the short 2-byte form when it fits, otherwise (and
   // sometimes anyway) in the 4-byte form flagged by the top bit.
   task automatic put_number(input logic [31:0] value);
      if (value > 32'h0000_7FFF || $urandom_range(0, 3) == 0) begin
         stream_bytes.push_back({1'b1, value[30:24]});
         stream_bytes.push_back(value[23:16]);
         stream_bytes.push_back(value[15:8]);
      end else begin
         stream_bytes.push_back({1'b0, value[14:8]});
      end
      stream_bytes.push_back(value[7:0]);
   endtask

   task automatic add_literal();
      logic [31:0] count;
      case ($urandom_range(0, 19))
         0:       count = $urandom_range(41, 255);
         1, 2, 3: count = $urandom_range(7, 40);
         default: count = $urandom_range(1, 6);
      endcase
      stream_bytes.push_back(count[7:0]);
      repeat (count) stream_bytes.push_back(rand_byte());
   endtask

   // A copy is built valid or deliberately invalid against the base length
   // that is in force while the stream is played.
   task automatic add_copy(input logic want_valid);
      logic [31:0] limit;
      logic [31:0] pos;
      logic [31:0] len;
      limit = {1'b0, base_size};
      if (want_valid && limit != 32'd0) begin
         pos = pick_between(32'd0, limit - 32'd1);
         len = pick_between(32'd0, limit - pos);
      end else if (limit != 32'd0 && $urandom_range(0, 1) == 1) begin
         // Start inside the base but run past its end.
         pos = pick_between(32'd0, limit - 32'd1);
         if (limit - pos == MAX_LEN) pos = 32'd1;
         len = pick_between(limit - pos + 32'd1, MAX_LEN);
      end else begin
         // Start at or past the end of the base; the length does not matter.
         pos = pick_between(limit, MAX_LEN);
         len = pick_between(32'd0, MAX_LEN);
      end
      stream_bytes.push_back(8'h00);
      put_number(pos);
      put_number(len);
   endtask

   // Moves the assembled stream into the send queue, flagging its last byte.
   task automatic emit_stream();
      req_type item;
      foreach (stream_bytes[i]) begin
         item.diff_byte  = stream_bytes[i];
         item.stream_end = (i == stream_bytes.size() - 1);
         pending_items.push_back(item);
      end
   endtask

   // Mostly well-formed streams with random content; one in ten is cut off
   // part way through and one in ten is raw noise rich in copy headers.
   task automatic add_stream();
      int unsigned style;
      int unsigned keep;
      style = $urandom_range(0, 9);
      stream_bytes.delete();
      if (style == 0) begin
         repeat ($urandom_range(1, 10)) begin
            stream_bytes.push_back(($urandom_range(0, 2) == 0) ? 8'h00 : rand_byte());
         end
      end else begin
         repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 99) < 55) add_literal();
            else add_copy($urandom_range(0, 99) < 85);
         end
         if (style == 1 && stream_bytes.size() > 1) begin
            keep = $urandom_range(1, stream_bytes.size() - 1);
            while (stream_bytes.size() > keep) void'(stream_bytes.pop_back());
         end
      end
      emit_stream();
   endtask

   // ------------------------------------------------------------------------
   // Sequencing helpers
   // ------------------------------------------------------------------------

   // Waits until every item is accepted and every result has arrived, then
   // lets the pipeline settle, since a header byte leaves no result behind.
   // Sampling on the falling edge sees all queues and valids after update.
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_valid || expected_rsps.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(posedge clock);
   endtask

   task automatic write_base_length(input logic [NUM_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      base_size = value;
   endtask

   task automatic report_mismatch(input string what);
      if (fail_count < 40) $display("ERROR: %s (result %0d)", what, results_checked);
      fail_count++;
   endtask

   // ------------------------------------------------------------------------
   // Driver: offers queued items and hands each accepted one to the predictor.
   // Valid is only lowered after an acceptance, never while an item waits.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) decode_byte(req_data);
         if (!req_valid || req_ready) begin
            if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each accepted result against the oldest expectation and
   // drives rsp_ready, including one long hold-off that lets the decoder's
   // internal queue fill up and push back on the input side.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected result of kind %0d", rsp_data.kind));
            end else begin
               if (rsp_data.kind !== expected_rsps[0].kind)
                  report_mismatch($sformatf("kind %0d, want %0d",
                                            rsp_data.kind, expected_rsps[0].kind));
               if (rsp_data.literal_value !== expected_rsps[0].literal_value)
                  report_mismatch($sformatf("literal_value %0h, want %0h",
                                            rsp_data.literal_value,
                                            expected_rsps[0].literal_value));
               if (rsp_data.copy_position !== expected_rsps[0].copy_position)
                  report_mismatch($sformatf("copy_position %0h, want %0h",
                                            rsp_data.copy_position,
                                            expected_rsps[0].copy_position));
               if (rsp_data.copy_length !== expected_rsps[0].copy_length)
                  report_mismatch($sformatf("copy_length %0h, want %0h",
                                            rsp_data.copy_length,
                                            expected_rsps[0].copy_length));
               if (rsp_data.run_end !== expected_rsps[0].run_end)
                  report_mismatch($sformatf("run_end %0b, want %0b",
                                            rsp_data.run_end, expected_rsps[0].run_end));
               void'(expected_rsps.pop_front());
            end
            results_checked++;
         end

         // The long hold-off starts only while plenty of items are still
         // waiting, so the sender keeps pushing into a full block.
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!long_stall_done && results_checked >= 300 &&
                      pending_items.size() > 20) begin
            stall_left      = 150;
            long_stall_done = 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus: reset, a directed set of streams, then random segments that
   // each run under their own base length, several with a new idling pattern.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      logic [NUM_W-1:0] next_base;
      logic [31:0]      raw;
      int unsigned      target;

      clear_parser();
      base_size = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // With the reset base length of zero, even a zero-length copy at
      // position zero is out of range; here it fails on the closing byte.
      stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      emit_stream();
      wait_idle();

      write_base_length(31'd100);
      // One literal of the largest byte value, closed at a command boundary.
      stream_bytes = '{8'h01, 8'hFF};
      emit_stream();
      // Short-form copy touching the last byte of the base.
      stream_bytes = '{8'h00, 8'h00, 8'h63, 8'h00, 8'h01};
      emit_stream();
      // Long-form position equal to the base length fails mid-stream; the
      // trailing bytes, including a literal header, are dropped silently.
      stream_bytes = '{8'h00, 8'h80, 8'h00, 8'h00, 8'h64, 8'h00, 8'h00, 8'h42, 8'h00};
      emit_stream();
      // Stream cut off inside a literal run: a literal, then invalid.
      stream_bytes = '{8'h02, 8'h00};
      emit_stream();
      // Stream cut off right after a copy header.
      stream_bytes = '{8'h00};
      emit_stream();
      // Copy with a long-form position covering the whole base, then a literal header that
      // ends the stream with its run still open.
      stream_bytes = '{8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h64, 8'hFF};
      emit_stream();
      wait_idle();

      for (int seg = 0; seg < 6; seg++) begin
         case (seg)
            0: begin
               send_gap_pct   = 23;
               recv_stall_pct = 53;
               next_base      = 31'd1000;
            end
            1: next_base = MAX_LEN[NUM_W-1:0];
            2: begin
               send_gap_pct   = 53;
               recv_stall_pct = 23;
               next_base      = 31'd1;
            end
            3: begin
               raw       = $urandom;
               next_base = raw[NUM_W-1:0];
            end
            4: begin
               send_gap_pct   = 0;
               recv_stall_pct = 0;
               next_base      = 31'h0000_8000;
            end
            default: next_base = '0;
         endcase
         write_base_length(next_base);
         target = 120;
         while (pending_items.size() < target) add_stream();
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Safety net far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
